FILE: hw/rtl/tbalm_pkg.sv
// Shared constants and types of the three-band level meter.
package tbalm_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned CoefW     = 16;
  localparam int unsigned StateW    = 24;
  localparam int unsigned SumW      = 46;
  localparam int unsigned TallyW    = 13;
  localparam int unsigned LevelW    = 16;
  localparam int unsigned RootW     = SumW / 2;
  localparam int unsigned CntW      = 6;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned MaxFrames = 4096;

  localparam logic [CoefW-1:0] BassCoefReset = 16'd1526;
  localparam logic [CoefW-1:0] MidCoefReset  = 16'd17669;

  localparam logic [CfgIdxW-1:0] CfgBassCoef = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMidCoef  = 2'd1;

  typedef struct packed {
    logic [SumW-1:0]    stereo;
    logic [SumW-1:0]    bass;
    logic [SumW-1:0]    mid;
    logic [SumW-1:0]    treble;
    logic [LevelW-1:0]  peak;
    logic [TallyW-1:0]  tally;
  } snap_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkDiv,
    BkSqrt,
    BkOut
  } back_state_e;

endpackage

FILE: hw/rtl/tbalm_front.sv
// Front end: accepts frames, runs the band filters and accumulates block sums.
module tbalm_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [tbalm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tbalm_pkg::CoefW-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [tbalm_pkg::SampleW-1:0] left_sample_i,
  input  logic signed [tbalm_pkg::SampleW-1:0] right_sample_i,
  input  logic                            last_frame_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output tbalm_pkg::snap_t                q_data_o
);
  import tbalm_pkg::*;

  logic [CoefW-1:0]          bass_coef_q, mid_coef_q;
  logic signed [StateW-1:0]  bass_q, bass_d, mid_q, mid_d;
  logic                      v1_q, v1_d;
  logic signed [SampleW-1:0] l1_q, r1_q;
  logic                      last1_q;
  logic signed [StateW-1:0]  mono1_q, mono;
  logic [SumW-1:0]           st_sum_q, bs_sum_q, md_sum_q, tr_sum_q;
  logic [SumW-1:0]           st_sum_n, bs_sum_n, md_sum_n, tr_sum_n;
  logic [LevelW-1:0]         peak_q, peak_n;
  logic [TallyW-1:0]         tally_q, tally_n;
  logic                      accept, hold, blk_end;
  logic signed [SampleW:0]   lr_sum;
  logic signed [StateW:0]    diff_b, diff_m, band_m, band_t;
  logic signed [41:0]        prod_b, prod_m;
  logic [SampleW:0]          al_w, ar_w;
  logic [SampleW-1:0]        al, ar, pk;
  logic [33:0]               st_sq, bs_sq, md_sq, tr_sq;

  function automatic logic [33:0] band_sq(input logic signed [StateW:0] b);
    logic signed [StateW+1:0] rb;
    logic signed [17:0]       w;
    logic [16:0]              mag;
    rb  = 26'(b) + 26'sd128;
    w   = rb[25:8];
    mag = w[17] ? 17'(-w) : w[16:0];
    return 34'(mag) * 34'(mag);
  endfunction

  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a, input logic [33:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + (SumW+1)'(b);
    return s[SumW] ? {SumW{1'b1}} : s[SumW-1:0];
  endfunction

  assign hold       = v1_q && blk_end && q_full_i;
  assign accept     = in_valid_i && !hold;
  assign in_stall_o = hold;

  always_comb begin
    lr_sum = 17'(left_sample_i) + 17'(right_sample_i);
    mono   = {lr_sum, 7'b0};
    diff_b = 25'(mono) - 25'(bass_q);
    diff_m = 25'(mono) - 25'(mid_q);
    prod_b = signed'({1'b0, bass_coef_q}) * diff_b + 42'sd32768;
    prod_m = signed'({1'b0, mid_coef_q}) * diff_m + 42'sd32768;
    bass_d = bass_q + prod_b[39:16];
    mid_d  = mid_q + prod_m[39:16];
  end

  always_comb begin
    al_w   = l1_q[SampleW-1] ? 17'(-17'(l1_q)) : 17'(l1_q);
    ar_w   = r1_q[SampleW-1] ? 17'(-17'(r1_q)) : 17'(r1_q);
    al     = al_w[SampleW-1:0];
    ar     = ar_w[SampleW-1:0];
    st_sq  = 34'(32'(al) * 32'(al)) + 34'(32'(ar) * 32'(ar));
    band_m = 25'(mid_q) - 25'(bass_q);
    band_t = 25'(mono1_q) - 25'(mid_q);
    bs_sq  = band_sq(25'(bass_q));
    md_sq  = band_sq(band_m);
    tr_sq  = band_sq(band_t);
    st_sum_n = sat_add(st_sum_q, st_sq);
    bs_sum_n = sat_add(bs_sum_q, bs_sq);
    md_sum_n = sat_add(md_sum_q, md_sq);
    tr_sum_n = sat_add(tr_sum_q, tr_sq);
    pk       = (al > ar) ? al : ar;
    peak_n   = (pk > peak_q) ? pk : peak_q;
    tally_n  = tally_q + 1'b1;
    blk_end  = last1_q || (tally_n == TallyW'(MaxFrames));
    v1_d     = accept ? 1'b1 : (hold ? v1_q : 1'b0);
  end

  assign q_push_o = v1_q && blk_end && !q_full_i;
  assign q_data_o = '{stereo: st_sum_n, bass: bs_sum_n, mid: md_sum_n, treble: tr_sum_n,
                      peak: peak_n, tally: tally_n};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bass_coef_q <= BassCoefReset;
      mid_coef_q  <= MidCoefReset;
      bass_q      <= '0;
      mid_q       <= '0;
      v1_q        <= 1'b0;
      st_sum_q    <= '0;
      bs_sum_q    <= '0;
      md_sum_q    <= '0;
      tr_sum_q    <= '0;
      peak_q      <= '0;
      tally_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_index_i == CfgBassCoef) begin
        bass_coef_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == CfgMidCoef) begin
        mid_coef_q <= cfg_data_i;
      end
      if (accept) begin
        bass_q <= bass_d;
        mid_q  <= mid_d;
      end
      v1_q <= v1_d;
      if (v1_q && !hold) begin
        if (blk_end) begin
          st_sum_q <= '0;
          bs_sum_q <= '0;
          md_sum_q <= '0;
          tr_sum_q <= '0;
          peak_q   <= '0;
          tally_q  <= '0;
        end else begin
          st_sum_q <= st_sum_n;
          bs_sum_q <= bs_sum_n;
          md_sum_q <= md_sum_n;
          tr_sum_q <= tr_sum_n;
          peak_q   <= peak_n;
          tally_q  <= tally_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      l1_q    <= left_sample_i;
      r1_q    <= right_sample_i;
      last1_q <= last_frame_i;
      mono1_q <= mono;
    end
  end

  a_tally_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tally_q < TallyW'(MaxFrames)) else $error("block tally reached its limit");
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v1_q) else $error("input stalled with an empty stage");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> !q_full_i) else $error("push into a full queue");

endmodule

FILE: hw/rtl/tbalm_queue.sv
// Two-entry queue of finished block sums between the front and back ends.
module tbalm_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  tbalm_pkg::snap_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output tbalm_pkg::snap_t pop_data_o
);
  import tbalm_pkg::*;

  snap_t       mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && empty_o)) else $error("queue overflow or underflow");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count out of range");
  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full_o && empty_o)) else $error("queue both full and empty");

endmodule

FILE: hw/rtl/tbalm_back.sv
// Back end: divides each block sum by the frame count, takes square roots, drives results.
module tbalm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  tbalm_pkg::snap_t              q_data_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tbalm_pkg::LevelW-1:0]  rms_level_o,
  output logic [tbalm_pkg::LevelW-1:0]  peak_level_o,
  output logic [tbalm_pkg::LevelW-1:0]  bass_level_o,
  output logic [tbalm_pkg::LevelW-1:0]  mid_level_o,
  output logic [tbalm_pkg::LevelW-1:0]  treble_level_o,
  output logic [tbalm_pkg::TallyW-1:0]  frames_in_block_o
);
  import tbalm_pkg::*;

  back_state_e        state_q, state_d;
  snap_t              snap_q;
  logic [1:0]         k_q, k_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [SumW-1:0]    dv_q, dv_d, dividend, dv_src;
  logic [TallyW-1:0]  rem_q, rem_d;
  logic [TallyW:0]    dsh;
  logic               dge;
  logic [SumW-1:0]    sv_q, sv_d;
  logic [RootW+2:0]   srem_q, srem_d, ssh, trial;
  logic               sge;
  logic [RootW-1:0]   root_q, root_d;
  logic [LevelW-1:0]  lvl_q [4];
  logic [LevelW-1:0]  lvl_sat;
  logic               out_valid_q, out_load, lvl_wr;
  logic               first_div;

  always_comb begin
    unique case (k_q)
      2'd0:    dividend = {1'b0, snap_q.stereo[SumW-1:1]};
      2'd1:    dividend = snap_q.bass;
      2'd2:    dividend = snap_q.mid;
      default: dividend = snap_q.treble;
    endcase
    dv_src  = first_div ? dividend : dv_q;
    dsh     = {rem_q, dv_src[SumW-1]};
    dge     = dsh >= {1'b0, snap_q.tally};
    ssh     = {srem_q[RootW:0], sv_q[SumW-1:SumW-2]};
    trial   = {1'b0, root_q, 2'b01};
    sge     = ssh >= trial;
    lvl_sat = (root_d > RootW'(16'hFFFF)) ? 16'hFFFF : root_d[LevelW-1:0];
  end

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    cnt_d    = cnt_q;
    dv_d     = dv_q;
    rem_d    = rem_q;
    sv_d     = sv_q;
    srem_d   = srem_q;
    root_d   = root_q;
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    lvl_wr   = 1'b0;
    unique case (state_q)
      BkIdle: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          k_d     = '0;
          state_d = BkDiv;
          cnt_d   = '0;
          rem_d   = '0;
          dv_d    = '0;
        end
      end
      BkDiv: begin
        rem_d = dge ? TallyW'(dsh - {1'b0, snap_q.tally}) : dsh[TallyW-1:0];
        dv_d  = {dv_src[SumW-2:0], dge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(SumW - 1)) begin
          state_d = BkSqrt;
          cnt_d   = '0;
          sv_d    = {dv_src[SumW-2:0], dge};
          srem_d  = '0;
          root_d  = '0;
        end
      end
      BkSqrt: begin
        srem_d = sge ? ssh - trial : ssh;
        root_d = {root_q[RootW-2:0], sge};
        sv_d   = {sv_q[SumW-3:0], 2'b00};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CntW'(RootW - 1)) begin
          lvl_wr = 1'b1;
          cnt_d  = '0;
          if (k_q == 2'd3) begin
            state_d = BkOut;
          end else begin
            k_d     = k_q + 1'b1;
            rem_d   = '0;
            state_d = BkDiv;
          end
        end
      end
      BkOut: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    srem_q <= srem_d;
    root_q <= root_d;
    sv_q   <= sv_d;
    if (state_q == BkSqrt && state_d == BkDiv) begin
      dv_q <= '0;
    end else begin
      dv_q <= dv_d;
    end
    if (q_pop_o) begin
      snap_q <= q_data_i;
    end
    if (lvl_wr) begin
      lvl_q[k_q] <= lvl_sat;
    end
    if (out_load) begin
      rms_level_o       <= lvl_q[0];
      peak_level_o      <= snap_q.peak;
      bass_level_o      <= lvl_q[1];
      mid_level_o       <= lvl_q[2];
      treble_level_o    <= lvl_q[3];
      frames_in_block_o <= snap_q.tally;
    end
  end

  // The dividend register is loaded at the first division cycle of each value.
  assign first_div = (state_q == BkDiv) && (cnt_q == '0);

  assign out_valid_o = out_valid_q;

  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BkDiv |-> cnt_q < CntW'(SumW)) else $error("division overran its steps");
  a_sqrt_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BkSqrt |-> cnt_q < CntW'(RootW)) else $error("root overran its steps");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q) else $error("stalled result dropped");

endmodule

FILE: hw/rtl/three_band_audio_level_meter.sv
// Top level of the three-band audio level meter.
//
// Frames enter on the input channel (in_valid_i, in_stall_o) with a left and
// right sample and a last_frame mark. Unless stalled, the front end takes
// one frame per cycle into a filter stage and an accumulate stage. A frame
// that ends a block, by its mark or by reaching 4096 frames, pushes the
// block sums into a two-entry queue; the input stalls only while it is full.
// The back end computes each of the four levels with a 46-step restoring
// divider and a 23-step square root. It works on one block at a time, so
// blocks that end before it is done back up into the queue and then the
// input. The result is held in an output
// register until out_stall_i is low. Configuration writes are always taken
// (cfg_ready_o is high) and should happen while the meter is idle.
// Reset clears the filters, the accumulators, the queue and the output,
// and restores the default coefficients.
module three_band_audio_level_meter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tbalm_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [tbalm_pkg::CoefW-1:0]          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [tbalm_pkg::SampleW-1:0] left_sample_i,
  input  logic signed [tbalm_pkg::SampleW-1:0] right_sample_i,
  input  logic                                 last_frame_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [tbalm_pkg::LevelW-1:0]         rms_level_o,
  output logic [tbalm_pkg::LevelW-1:0]         peak_level_o,
  output logic [tbalm_pkg::LevelW-1:0]         bass_level_o,
  output logic [tbalm_pkg::LevelW-1:0]         mid_level_o,
  output logic [tbalm_pkg::LevelW-1:0]         treble_level_o,
  output logic [tbalm_pkg::TallyW-1:0]         frames_in_block_o
);
  import tbalm_pkg::*;

  logic  q_full, q_push, q_empty, q_pop;
  snap_t q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  tbalm_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .left_sample_i,
    .right_sample_i,
    .last_frame_i,
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  tbalm_queue u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_rdata)
  );

  tbalm_back u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .out_valid_o,
    .out_stall_i,
    .rms_level_o,
    .peak_level_o,
    .bass_level_o,
    .mid_level_o,
    .treble_level_o,
    .frames_in_block_o
  );

endmodule

FILE: verif/tb_three_band_audio_level_meter.sv
// Testbench of the three-band level meter: directed and random frames against a predictor, checked per block.
module tb_three_band_audio_level_meter;
  timeunit 1ns;
  timeprecision 1ps;
  import tbalm_pkg::*;

  typedef struct packed {
    logic [LevelW-1:0] rms;
    logic [LevelW-1:0] peak;
    logic [LevelW-1:0] bass;
    logic [LevelW-1:0] mid;
    logic [LevelW-1:0] treble;
    logic [TallyW-1:0] frames;
  } meter_result_t;

  class level_scoreboard;
    localparam longint unsigned SumMax = (64'd1 << SumW) - 1;
    bit [CoefW-1:0] bass_coef = BassCoefReset;
    bit [CoefW-1:0] mid_coef = MidCoefReset;
    longint bass_lp, mid_lp;
    longint unsigned stereo_sum, bass_sum, mid_sum, treble_sum, peak_abs, tally;
    meter_result_t expected_blocks[$];
    int errors;

    function void set_register(bit [CfgIdxW-1:0] idx, bit [CoefW-1:0] value);
      if (idx == CfgBassCoef) bass_coef = value;
      else if (idx == CfgMidCoef) mid_coef = value;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function logic [LevelW-1:0] band_level(longint unsigned sum, longint unsigned div);
      longint unsigned r;
      if (div == 0) return 0;
      r = int_sqrt(sum / div);
      return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    function longint lowpass(longint s, longint x, bit [CoefW-1:0] alpha);
      longint p;
      p = longint'(alpha) * (x - s) + 32768;
      return s + (p >>> 16);
    endfunction

    function longint unsigned band_square(longint b);
      longint w;
      w = (b + 128) >>> 8;
      if (w < 0) w = -w;
      return w * w;
    endfunction

    function longint unsigned sat_sum(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s > SumMax) ? SumMax : s;
    endfunction

    function void note_frame(logic signed [SampleW-1:0] left, logic signed [SampleW-1:0] right,
                             logic last);
      longint l, r, mono;
      longint unsigned al, ar;
      meter_result_t res;
      l = left;
      r = right;
      mono = (l + r) * 128;
      al = (l < 0) ? -l : l;
      ar = (r < 0) ? -r : r;
      bass_lp = lowpass(bass_lp, mono, bass_coef);
      mid_lp = lowpass(mid_lp, mono, mid_coef);
      stereo_sum = sat_sum(stereo_sum, al * al + ar * ar);
      bass_sum = sat_sum(bass_sum, band_square(bass_lp));
      mid_sum = sat_sum(mid_sum, band_square(mid_lp - bass_lp));
      treble_sum = sat_sum(treble_sum, band_square(mono - mid_lp));
      if (al > peak_abs) peak_abs = al;
      if (ar > peak_abs) peak_abs = ar;
      if (peak_abs > 65535) peak_abs = 65535;
      tally++;
      if (!last && tally < MaxFrames) return;
      res.rms = band_level(stereo_sum, 2 * tally);
      res.peak = peak_abs[15:0];
      res.bass = band_level(bass_sum, tally);
      res.mid = band_level(mid_sum, tally);
      res.treble = band_level(treble_sum, tally);
      res.frames = tally[12:0];
      expected_blocks.push_back(res);
      stereo_sum = 0; bass_sum = 0; mid_sum = 0; treble_sum = 0; peak_abs = 0; tally = 0;
    endfunction

    function void check_result(meter_result_t got);
      meter_result_t want;
      if (expected_blocks.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected block result: frames %0d", got.frames);
        return;
      end
      want = expected_blocks.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("Block mismatch: exp rms %0d pk %0d b %0d m %0d t %0d n %0d, got rms %0d pk %0d b %0d m %0d t %0d n %0d",
                   want.rms, want.peak, want.bass, want.mid, want.treble, want.frames,
                   got.rms, got.peak, got.bass, got.mid, got.treble, got.frames);
      end
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CoefW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [SampleW-1:0] left_sample_i = '0;
  logic signed [SampleW-1:0] right_sample_i = '0;
  logic last_frame_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [LevelW-1:0] rms_level_o, peak_level_o, bass_level_o, mid_level_o, treble_level_o;
  logic [TallyW-1:0] frames_in_block_o;

  level_scoreboard sb = new;
  bit calm = 1'b0;
  int stall_hold = 0;

  three_band_audio_level_meter u_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    meter_result_t got;
    if (out_valid_o && !out_stall_i) begin
      got.rms = rms_level_o;
      got.peak = peak_level_o;
      got.bass = bass_level_o;
      got.mid = mid_level_o;
      got.treble = treble_level_o;
      got.frames = frames_in_block_o;
      sb.check_result(got);
    end
    if (stall_hold == 0) begin
      if (calm || $urandom_range(0, 99) < 60) begin
        out_stall_i <= 1'b0;
        stall_hold = $urandom_range(1, 20);
      end else begin
        out_stall_i <= 1'b1;
        stall_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
      end
    end else begin
      stall_hold--;
    end
  end

  task automatic send_frame(logic signed [SampleW-1:0] l, logic signed [SampleW-1:0] r,
                            logic last);
    int gap;
    int pick;
    pick = $urandom_range(0, 99);
    gap = (calm || pick < 60) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    left_sample_i <= l;
    right_sample_i <= r;
    last_frame_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_frame(l, r, last);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CoefW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_register(idx, value);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic signed [SampleW-1:0] pick_sample(int style, logic signed [15:0] dc);
    case (style)
      0: return SampleW'($urandom());
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      2: return SampleW'($signed($urandom_range(0, 200)) - 100);
      default: return dc;
    endcase
  endfunction

  task automatic random_blocks(int items);
    int sent, len, style;
    logic signed [15:0] dc;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
      style = $urandom_range(0, 3);
      dc = 16'($urandom());
      for (int i = 0; i < len; i++)
        send_frame(pick_sample(style, dc), pick_sample(style, dc), i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_frame(16'sh8000, 16'sh8000, 1'b1);
    send_frame(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_frame(16'sh0000, 16'sh0000, 1'b1);
    send_frame(16'sh7FFF, 16'sh8000, 1'b1);
    send_frame(16'sh8000, 16'sh7FFF, 1'b1);
    send_frame(-16'sd1, 16'sd1, 1'b1);
    send_frame(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_frame(16'sh8000, 16'sh8000, 1'b0);
    send_frame(16'sh7FFF, 16'sh8000, 1'b0);
    send_frame(16'sh0000, 16'sh0000, 1'b1);
    for (int i = 0; i < 10; i++) send_frame(SampleW'(i * 300), SampleW'(-i * 700), i == 9);
    drain();

    write_register(CfgBassCoef, 16'h0000);
    write_register(CfgMidCoef, 16'h0000);
    random_blocks(250);
    drain();

    calm = 1'b1;
    write_register(CfgBassCoef, 16'hFFFF);
    write_register(CfgMidCoef, 16'hFFFF);
    random_blocks(200);
    // A block that never sees last_frame ends itself at the frame limit.
    for (int i = 0; i < MaxFrames; i++)
      send_frame(SampleW'($urandom()), SampleW'($urandom()), 1'b0);
    drain();
    calm = 1'b0;

    write_register(2'd2, 16'h1234);
    write_register(2'd3, 16'hFFFF);
    write_register(CfgBassCoef, CoefW'($urandom()));
    write_register(CfgMidCoef, CoefW'($urandom()));
    random_blocks(300);
    drain();

    write_register(CfgBassCoef, 16'hAAAA);
    write_register(CfgMidCoef, 16'h5555);
    random_blocks(300);
    drain();

    write_register(CfgBassCoef, BassCoefReset);
    write_register(CfgMidCoef, MidCoefReset);
    random_blocks(400);
    drain();
    repeat (300) @(posedge clk_i);

    if (sb.pending() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

FILE: files.f
hw/rtl/tbalm_pkg.sv
hw/rtl/tbalm_front.sv
hw/rtl/tbalm_queue.sv
hw/rtl/tbalm_back.sv
hw/rtl/three_band_audio_level_meter.sv
verif/tb_three_band_audio_level_meter.sv
